### src/binary_min_heap_priority_queue_top_macros.svh
// Assertion macros for the binary min-heap priority queue.
// Used by the top level only; no other dependencies.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define BMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bmh_pkg.sv
// Shared types and codes for the binary min-heap priority queue.
// No dependencies.
`default_nettype none

package bmh_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_DECREASE = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_flags_type;

endpackage

`default_nettype wire

### src/bmh_keyunit.sv
// Shared key unit: signed compare, equality and saturating decrement.
// Depends on bmh_pkg.
`default_nettype none

module bmh_keyunit
   import bmh_pkg::*;
#(
   parameter int KEY_WIDTH = 32
) (
   input  wire logic signed [KEY_WIDTH-1:0] a,
   input  wire logic signed [KEY_WIDTH-1:0] b,
   input  wire logic        [30:0]          amount,
   output cmp_flags_type                    flags,
   output logic signed [KEY_WIDTH-1:0]      dec
);

   localparam int SW = ((KEY_WIDTH > 31) ? KEY_WIDTH : 31) + 1;

   logic [KEY_WIDTH-1:0] sign_bit;
   logic [KEY_WIDTH-1:0] biased;
   logic [SW-1:0]        biased_w;
   logic [SW-1:0]        amount_w;
   logic [SW-1:0]        diff_w;

   assign flags.lt = (a < b);
   assign flags.eq = (a == b);

   // offset-binary so the floor is zero
   assign sign_bit = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   assign biased   = a ^ sign_bit;
   assign biased_w = SW'(biased);
   assign amount_w = SW'(amount);
   assign diff_w   = (biased_w < amount_w) ? '0 : (biased_w - amount_w);
   assign dec      = diff_w[KEY_WIDTH-1:0] ^ sign_bit;

endmodule

`default_nettype wire

### src/binary_min_heap_priority_queue_top.sv
// Binary min-heap priority queue: one request (insert, extract-min, decrease-key,
// remove) gives one response. An insert climbs the heap one level at a time;
// extract-min descends one level at a time from the root; decrease-key and
// remove first scan the held entries in array order, then sift. Each step is
// paced by the single-port heap memory (one access per cycle, registered read) and
// the one shared key compare unit. req_tready is high only while idle; a finished
// response waits in the output register without holding up the next request.
// Depends on bmh_pkg, bmh_keyunit and the macros header.
`default_nettype none

`include "binary_min_heap_priority_queue_top_macros.svh"

module binary_min_heap_priority_queue_top
   import bmh_pkg::*;
#(
   parameter int CAPACITY  = 32,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key[31:0], amount[62:32], zero[63]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // value[31:0], count[37:32], zero[39:38]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_ROOT_RD, S_ROOT_GET, S_TAKE, S_LAST_GET,
      S_DN_LRD, S_DN_LCMP, S_DN_RRD, S_DN_RCMP, S_DN_MOVE,
      S_FIND_RD, S_FIND_CMP, S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   status_type                  status_ff, status_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [30:0]                 amt_ff, amt_in;
   logic signed [KEY_WIDTH-1:0] cur_ff, cur_in;
   logic signed [KEY_WIDTH-1:0] best_ff, best_in;
   logic signed [KEY_WIDTH-1:0] value_ff, value_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               sel_ff, sel_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_value_ff, rsp_value_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [5:0]                  rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH-1:0]        heap_mem [CAPACITY];
   logic signed [KEY_WIDTH-1:0] rd_ff;
   logic                        mem_we;
   logic [IW-1:0]               mem_addr;
   logic [KEY_WIDTH-1:0]        mem_wdata;

   logic signed [KEY_WIDTH-1:0] cu_a, cu_b, cu_dec;
   cmp_flags_type               cu_flags;

   logic signed [63:0]          key64;
   logic signed [63:0]          val64;
   logic [CW+5:0]               count_ext;
   logic [XW-1:0]               idx_x, left_x, right_x, count_x;
   logic [CW-1:0]               parent_idx;

   bmh_keyunit #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_keyunit (
      .a      (cu_a),
      .b      (cu_b),
      .amount (amt_ff),
      .flags  (cu_flags),
      .dec    (cu_dec)
   );

   assign key64      = 64'(signed'(req_tdata[31:0]));
   assign val64      = 64'(value_ff);
   assign count_ext  = {6'b0, count_ff};
   assign idx_x      = XW'(idx_ff);
   assign left_x     = {idx_x[XW-2:0], 1'b0} + XW'(1);
   assign right_x    = {idx_x[XW-2:0], 1'b0} + XW'(2);
   assign count_x    = XW'(count_ff);
   assign parent_idx = (idx_ff - CW'(1)) >> 1;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      case (state_ff)
         S_UP_CMP: begin
            cu_a = cur_ff;
            cu_b = rd_ff;
         end
         S_DN_RCMP: begin
            cu_a = rd_ff;
            cu_b = best_ff;
         end
         S_FIND_CMP: begin
            cu_a = rd_ff;
            cu_b = key_ff;
         end
         default: begin
            cu_a = rd_ff;
            cu_b = cur_ff;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      sel_in        = sel_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_addr      = idx_ff[IW-1:0];
      mem_wdata     = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = op_type'(req_tuser);
               key_in    = key64[KEY_WIDTH-1:0];
               amt_in    = req_tdata[62:32];
               value_in  = '0;
               status_in = ST_OK;
               idx_in    = '0;
               case (op_type'(req_tuser))
                  OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        cur_in   = key64[KEY_WIDTH-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_RD;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ROOT_RD;
                     end
                  end
                  default: state_in = S_FIND_RD;
               endcase
            end
         end
         S_UP_RD: begin
            if (idx_ff == '0) begin
               if (op_ff == OP_REMOVE) begin
                  state_in = S_TAKE;
               end else begin
                  mem_we   = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               mem_addr = parent_idx[IW-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            if (op_ff == OP_REMOVE || cu_flags.lt) begin
               mem_wdata = rd_ff;
               idx_in    = parent_idx;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ROOT_RD: begin
            mem_addr = '0;
            state_in = S_ROOT_GET;
         end
         S_ROOT_GET: begin
            value_in = rd_ff;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            count_in = count_ff - CW'(1);
            mem_addr = count_in[IW-1:0];
            if (count_ff == CW'(1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LAST_GET;
            end
         end
         S_LAST_GET: begin
            cur_in   = rd_ff;
            idx_in   = '0;
            state_in = S_DN_LRD;
         end
         S_DN_LRD: begin
            if (left_x >= count_x) begin
               mem_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               mem_addr = left_x[IW-1:0];
               state_in = S_DN_LCMP;
            end
         end
         S_DN_LCMP: begin
            if (cu_flags.lt) begin
               best_in = rd_ff;
               sel_in  = left_x[CW-1:0];
            end else begin
               best_in = cur_ff;
               sel_in  = idx_ff;
            end
            state_in = S_DN_RRD;
         end
         S_DN_RRD: begin
            if (right_x >= count_x) begin
               state_in = S_DN_MOVE;
            end else begin
               mem_addr = right_x[IW-1:0];
               state_in = S_DN_RCMP;
            end
         end
         S_DN_RCMP: begin
            if (cu_flags.lt) begin
               best_in = rd_ff;
               sel_in  = right_x[CW-1:0];
            end
            state_in = S_DN_MOVE;
         end
         S_DN_MOVE: begin
            mem_we = 1'b1;
            if (sel_ff == idx_ff) begin
               state_in = S_DONE;
            end else begin
               mem_wdata = best_ff;
               idx_in    = sel_ff;
               state_in  = S_DN_LRD;
            end
         end
         S_FIND_RD: begin
            if (idx_ff >= count_ff) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (cu_flags.eq) begin
               if (op_ff == OP_DECREASE) begin
                  cur_in = cu_dec;
               end else begin
                  value_in = rd_ff;
               end
               state_in = S_UP_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val64[31:0];
               rsp_status_in = status_ff;
               rsp_count_in  = count_ext[5:0];
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= heap_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      sel_ff        <= sel_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BMH_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count over capacity")
   `BMH_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE, "request accepted but still idle")
   `BMH_ASSERT_NOW(a_full_status, clock, reset, state_ff == S_DONE && status_ff == ST_FULL, count_ff == CW'(CAPACITY), "full status while not full")
   `BMH_ASSERT_NOW(a_empty_status, clock, reset, state_ff == S_DONE && status_ff == ST_EMPTY, count_ff == '0, "empty status while holding entries")

endmodule

`default_nettype wire
